// ===== sv/psrs_pkg.sv =====
// Package for the principal strain rate stencil block.
// Payload types, register indexes and pipeline constants; no dependencies.
`default_nettype none

package psrs_pkg;

  localparam int VEL_W   = 32;
  localparam int INV_W   = 32;
  localparam int FLAGS_W = 4;
  localparam int OUT_W   = 48;

  // Difference of two Q16.16 velocities, and its product with a Q0.32 factor.
  localparam int DIFF_W = VEL_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  // Gradients and A/B/Dxy in Q.40, with headroom for the sums.
  localparam int GRAD_W = 58;
  localparam int MAG_W  = 57;
  localparam int LO_W   = 29;
  localparam int HI_W   = MAG_W - LO_W;

  // Square root: radicand, root and partial remainder widths.
  localparam int RAD_W  = 116;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int SUM_W  = 60;

  // Front stages (diff, product, gradient, abs, partials, squares, radicand),
  // one sqrt stage per root bit, and the output register.
  localparam int FRONT_STAGES = 7;
  localparam int LATENCY      = FRONT_STAGES + ROOT_W + 1;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_SPACING_X = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_SPACING_Y = 1'd1;
  localparam logic [INV_W-1:0] INV_SPACING_RESET = 32'd4294967;

  // free_flags bit positions
  localparam int FLAG_EAST  = 0;
  localparam int FLAG_WEST  = 1;
  localparam int FLAG_NORTH = 2;
  localparam int FLAG_SOUTH = 3;

  localparam int SHIFT_ONE_SIDED = 8;
  localparam int SHIFT_CENTRAL   = 9;

  typedef struct packed {
    logic signed [VEL_W-1:0]   u_center;
    logic signed [VEL_W-1:0]   v_center;
    logic signed [VEL_W-1:0]   u_east;
    logic signed [VEL_W-1:0]   v_east;
    logic signed [VEL_W-1:0]   u_west;
    logic signed [VEL_W-1:0]   v_west;
    logic signed [VEL_W-1:0]   u_north;
    logic signed [VEL_W-1:0]   v_north;
    logic signed [VEL_W-1:0]   u_south;
    logic signed [VEL_W-1:0]   v_south;
    logic        [FLAGS_W-1:0] free_flags;
  } stencil_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] strain_major;
    logic signed [OUT_W-1:0] strain_minor;
  } strain_t;

endpackage

`default_nettype wire

// ===== sv/principal_strain_rate_stencil_top.sv =====
// Principal strain rate pipeline: stencil differences, gradients, hypot, eigenvalues.
// Depends on psrs_pkg for payload types and constants.
// The start transfer passes 7 front stages, 58 square-root stages at one root bit
// each and one output register on its way to the done strobe.
// One cell per cycle while busy is low; busy is high in reset and the cycle after it.
// Synchronous reset clears all valid bits, holds busy high through reset and the cycle
// after it, and returns the spacing registers to their reset values. No receiver stall.
`default_nettype none

module principal_strain_rate_stencil_top (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  wire  psrs_pkg::stencil_t            in_item,
  input  wire                                 cfg_we,
  input  wire  [psrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [psrs_pkg::INV_W-1:0]          cfg_data,
  output logic                                done,
  output psrs_pkg::strain_t                   result
);

  localparam int DIFF_W = psrs_pkg::DIFF_W;
  localparam int PROD_W = psrs_pkg::PROD_W;
  localparam int GRAD_W = psrs_pkg::GRAD_W;
  localparam int MAG_W  = psrs_pkg::MAG_W;
  localparam int LO_W   = psrs_pkg::LO_W;
  localparam int HI_W   = psrs_pkg::HI_W;
  localparam int RAD_W  = psrs_pkg::RAD_W;
  localparam int ROOT_W = psrs_pkg::ROOT_W;
  localparam int REM_W  = psrs_pkg::REM_W;
  localparam int SUM_W  = psrs_pkg::SUM_W;
  localparam int OUT_W  = psrs_pkg::OUT_W;
  localparam int INV_W  = psrs_pkg::INV_W;

  logic accept;
  assign accept = start && !busy;

  // ---------------- configuration ----------------
  logic [INV_W-1:0] inv_x;
  logic [INV_W-1:0] inv_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_x <= psrs_pkg::INV_SPACING_RESET;
      inv_y <= psrs_pkg::INV_SPACING_RESET;
      busy  <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          psrs_pkg::CFG_INV_SPACING_X: inv_x <= cfg_data;
          psrs_pkg::CFG_INV_SPACING_Y: inv_y <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ---------------- stage 1: stencil differences ----------------
  logic signed [DIFF_W-1:0] dux_next, dvx_next, duy_next, dvy_next;
  logic                     x_one_next, y_one_next;
  logic                     fe, fw, fn, fs;

  assign fe = in_item.free_flags[psrs_pkg::FLAG_EAST];
  assign fw = in_item.free_flags[psrs_pkg::FLAG_WEST];
  assign fn = in_item.free_flags[psrs_pkg::FLAG_NORTH];
  assign fs = in_item.free_flags[psrs_pkg::FLAG_SOUTH];

  always_comb begin
    dux_next   = '0;
    dvx_next   = '0;
    x_one_next = 1'b1;
    if (fe && fw) begin
      dux_next = '0;
      dvx_next = '0;
    end else if (fw) begin
      dux_next = DIFF_W'(in_item.u_east) - DIFF_W'(in_item.u_center);
      dvx_next = DIFF_W'(in_item.v_east) - DIFF_W'(in_item.v_center);
    end else if (fe) begin
      dux_next = DIFF_W'(in_item.u_center) - DIFF_W'(in_item.u_west);
      dvx_next = DIFF_W'(in_item.v_center) - DIFF_W'(in_item.v_west);
    end else begin
      dux_next   = DIFF_W'(in_item.u_east) - DIFF_W'(in_item.u_west);
      dvx_next   = DIFF_W'(in_item.v_east) - DIFF_W'(in_item.v_west);
      x_one_next = 1'b0;
    end
  end

  always_comb begin
    duy_next   = '0;
    dvy_next   = '0;
    y_one_next = 1'b1;
    if (fn && fs) begin
      duy_next = '0;
      dvy_next = '0;
    end else if (fs) begin
      duy_next = DIFF_W'(in_item.u_north) - DIFF_W'(in_item.u_center);
      dvy_next = DIFF_W'(in_item.v_north) - DIFF_W'(in_item.v_center);
    end else if (fn) begin
      duy_next = DIFF_W'(in_item.u_center) - DIFF_W'(in_item.u_south);
      dvy_next = DIFF_W'(in_item.v_center) - DIFF_W'(in_item.v_south);
    end else begin
      duy_next   = DIFF_W'(in_item.u_north) - DIFF_W'(in_item.u_south);
      dvy_next   = DIFF_W'(in_item.v_north) - DIFF_W'(in_item.v_south);
      y_one_next = 1'b0;
    end
  end

  logic                     s1_vld, s1_zero, s1_x_one, s1_y_one;
  logic signed [DIFF_W-1:0] s1_dux, s1_dvx, s1_duy, s1_dvy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
    s1_zero  <= (in_item.u_center == '0) || (in_item.v_center == '0);
    s1_x_one <= x_one_next;
    s1_y_one <= y_one_next;
    s1_dux   <= dux_next;
    s1_dvx   <= dvx_next;
    s1_duy   <= duy_next;
    s1_dvy   <= dvy_next;
  end

  // ---------------- stage 2: scale by reciprocal spacing ----------------
  logic signed [DIFF_W-1:0] inv_x_s, inv_y_s;
  assign inv_x_s = $signed({1'b0, inv_x});
  assign inv_y_s = $signed({1'b0, inv_y});

  logic                     s2_vld, s2_zero, s2_x_one, s2_y_one;
  logic signed [PROD_W-1:0] s2_pux, s2_pvx, s2_puy, s2_pvy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_zero  <= s1_zero;
    s2_x_one <= s1_x_one;
    s2_y_one <= s1_y_one;
    s2_pux   <= s1_dux * inv_x_s;
    s2_pvx   <= s1_dvx * inv_x_s;
    s2_puy   <= s1_duy * inv_y_s;
    s2_pvy   <= s1_dvy * inv_y_s;
  end

  // ---------------- stage 3: gradients and A, B, Dxy ----------------
  // Arithmetic shifts floor toward minus infinity, as do the halvings.
  logic signed [PROD_W-1:0] ux_w, vx_w, uy_w, vy_w;
  logic signed [GRAD_W:0]   ux, vx, uy, vy;
  logic signed [GRAD_W:0]   a_sum, b_sum, d_sum;

  always_comb begin
    ux_w  = s2_x_one ? (s2_pux >>> psrs_pkg::SHIFT_ONE_SIDED)
                     : (s2_pux >>> psrs_pkg::SHIFT_CENTRAL);
    vx_w  = s2_x_one ? (s2_pvx >>> psrs_pkg::SHIFT_ONE_SIDED)
                     : (s2_pvx >>> psrs_pkg::SHIFT_CENTRAL);
    uy_w  = s2_y_one ? (s2_puy >>> psrs_pkg::SHIFT_ONE_SIDED)
                     : (s2_puy >>> psrs_pkg::SHIFT_CENTRAL);
    vy_w  = s2_y_one ? (s2_pvy >>> psrs_pkg::SHIFT_ONE_SIDED)
                     : (s2_pvy >>> psrs_pkg::SHIFT_CENTRAL);
    ux    = ux_w[GRAD_W:0];
    vx    = vx_w[GRAD_W:0];
    uy    = uy_w[GRAD_W:0];
    vy    = vy_w[GRAD_W:0];
    a_sum = ux + vy;
    b_sum = ux - vy;
    d_sum = vx + uy;
  end

  logic                     s3_vld, s3_zero;
  logic signed [GRAD_W-1:0] s3_a, s3_b, s3_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_zero <= s2_zero;
    s3_a    <= a_sum[GRAD_W:1];
    s3_b    <= b_sum[GRAD_W:1];
    s3_d    <= d_sum[GRAD_W:1];
  end

  // ---------------- stage 4: magnitudes ----------------
  logic                     s4_vld, s4_zero;
  logic signed [GRAD_W-1:0] s4_a;
  logic        [MAG_W-1:0]  s4_bm, s4_dm;
  logic signed [GRAD_W-1:0] b_abs, d_abs;

  assign b_abs = s3_b[GRAD_W-1] ? -s3_b : s3_b;
  assign d_abs = s3_d[GRAD_W-1] ? -s3_d : s3_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_zero <= s3_zero;
    s4_a    <= s3_a;
    s4_bm   <= b_abs[MAG_W-1:0];
    s4_dm   <= d_abs[MAG_W-1:0];
  end

  // ---------------- stage 5: partial products of the squares ----------------
  logic                     s5_vld, s5_zero;
  logic signed [GRAD_W-1:0] s5_a;
  logic [2*HI_W-1:0]        s5_bhh, s5_dhh;
  logic [HI_W+LO_W-1:0]     s5_bhl, s5_dhl;
  logic [2*LO_W-1:0]        s5_bll, s5_dll;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
    s5_zero <= s4_zero;
    s5_a    <= s4_a;
    s5_bhh  <= s4_bm[MAG_W-1:LO_W] * s4_bm[MAG_W-1:LO_W];
    s5_bhl  <= s4_bm[MAG_W-1:LO_W] * s4_bm[LO_W-1:0];
    s5_bll  <= s4_bm[LO_W-1:0] * s4_bm[LO_W-1:0];
    s5_dhh  <= s4_dm[MAG_W-1:LO_W] * s4_dm[MAG_W-1:LO_W];
    s5_dhl  <= s4_dm[MAG_W-1:LO_W] * s4_dm[LO_W-1:0];
    s5_dll  <= s4_dm[LO_W-1:0] * s4_dm[LO_W-1:0];
  end

  // ---------------- stage 6: assemble squares ----------------
  logic                     s6_vld, s6_zero;
  logic signed [GRAD_W-1:0] s6_a;
  logic [RAD_W-1:0]         s6_b2, s6_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= s5_vld;
    end
    s6_zero <= s5_zero;
    s6_a    <= s5_a;
    s6_b2   <= (RAD_W'(s5_bhh) << (2 * LO_W)) + (RAD_W'(s5_bhl) << (LO_W + 1))
             + RAD_W'(s5_bll);
    s6_d2   <= (RAD_W'(s5_dhh) << (2 * LO_W)) + (RAD_W'(s5_dhl) << (LO_W + 1))
             + RAD_W'(s5_dll);
  end

  // ---------------- stage 7 and square root pipeline ----------------
  // Stage 0 of the sqrt arrays is the radicand register; each later stage
  // resolves one root bit, most significant first.
  logic                     sq_vld  [0:ROOT_W];
  logic                     sq_zero [0:ROOT_W];
  logic signed [GRAD_W-1:0] sq_a    [0:ROOT_W];
  logic [RAD_W-1:0]         sq_rad  [0:ROOT_W];
  logic [REM_W-1:0]         sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]        sq_root [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= s6_vld;
    end
    sq_zero[0] <= s6_zero;
    sq_a[0]    <= s6_a;
    sq_rad[0]  <= s6_b2 + s6_d2;
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_sh = {sq_rem[i][REM_W-3:0], sq_rad[i][RAD_W-1:RAD_W-2]};
    assign trial  = REM_W'({sq_root[i], 2'b01});
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[i+1] <= 1'b0;
      end else begin
        sq_vld[i+1] <= sq_vld[i];
      end
      sq_zero[i+1] <= sq_zero[i];
      sq_a[i+1]    <= sq_a[i];
      sq_rad[i+1]  <= sq_rad[i] << 2;
      sq_rem[i+1]  <= fits ? (rem_sh - trial) : rem_sh;
      sq_root[i+1] <= {sq_root[i][ROOT_W-2:0], fits};
    end
  end

  // ---------------- output: A +/- q, saturate ----------------
  logic signed [SUM_W-1:0] a_ext, q_ext, major_sum, minor_sum;

  assign a_ext     = SUM_W'(sq_a[ROOT_W]);
  assign q_ext     = $signed(SUM_W'(sq_root[ROOT_W]));
  assign major_sum = a_ext + q_ext;
  assign minor_sum = a_ext - q_ext;

  function automatic logic signed [OUT_W-1:0] sat48(input logic signed [SUM_W-1:0] x);
    logic in_range;
    in_range = (x[SUM_W-1:OUT_W-1] == '0) || (x[SUM_W-1:OUT_W-1] == '1);
    if (in_range) begin
      return x[OUT_W-1:0];
    end else if (x[SUM_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_vld[ROOT_W];
    end
    if (sq_zero[ROOT_W]) begin
      result.strain_major <= '0;
      result.strain_minor <= '0;
    end else begin
      result.strain_major <= sat48(major_sum);
      result.strain_minor <= sat48(minor_sum);
    end
  end

  // ---------------- assertions ----------------
  // Every done strobe comes from an accepted start transfer.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, psrs_pkg::LATENCY))
    else $error("done without matching start transfer");

  // A zero center velocity forces both results to zero.
  a_zero_center: assert property (@(posedge clk) disable iff (rst)
    done && $past(accept && ((in_item.u_center == '0) || (in_item.v_center == '0)),
                  psrs_pkg::LATENCY)
    |-> (result.strain_major == '0) && (result.strain_minor == '0))
    else $error("zero center did not give zero strain");

  // q is never negative and saturation is monotone.
  a_major_ge_minor: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.strain_major >= result.strain_minor))
    else $error("major strain below minor strain");

  // No transfer is taken in the cycle right after reset.
  a_busy_after_reset: assert property (@(posedge clk)
    rst |=> busy)
    else $error("busy low right after reset");

endmodule

`default_nettype wire
